### rtl/bgme_pkg.sv
package bgme_pkg;

   localparam int WINDOW_MAX_DEF = 32;
   localparam int ADC_BITS_DEF = 12;

   // job length field covers the whole window range
   localparam int LEN_W = 7;

   localparam int CSR_IDX_W = 2;
   localparam int CSR_DATA_W = 24;
   localparam logic [CSR_IDX_W-1:0] REG_SAMPLES = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_ALPHA = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_SCALE = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHARGE = 2'd3;

   localparam int MV_W = 14;
   localparam int PCT_W = 7;
   localparam int ALPHA_W = 17;
   localparam int SCALE_W = 24;
   localparam int EMA_W = 30;

   localparam logic [MV_W-1:0] V_SAT = 14'd16383;
   localparam logic [ALPHA_W-1:0] ALPHA_MIN = 17'd655;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

   typedef struct packed {
      logic bank;
      logic [LEN_W-1:0] len;
      logic charging;
   } gauge_job_type;

   typedef struct packed {
      logic valid;
      logic bank;
   } gauge_release_type;

   function automatic logic [MV_W-1:0] tbl_mv(input logic [3:0] idx);
      logic [MV_W-1:0] r;
      unique case (idx)
         4'd0: r = 14'd4200;
         4'd1: r = 14'd4050;
         4'd2: r = 14'd3920;
         4'd3: r = 14'd3860;
         4'd4: r = 14'd3800;
         4'd5: r = 14'd3750;
         4'd6: r = 14'd3700;
         4'd7: r = 14'd3650;
         4'd8: r = 14'd3600;
         4'd9: r = 14'd3550;
         default: r = 14'd3300;
      endcase
      return r;
   endfunction

   function automatic logic [PCT_W-1:0] tbl_pct(input logic [3:0] idx);
      logic [PCT_W-1:0] r;
      unique case (idx)
         4'd0: r = 7'd100;
         4'd1: r = 7'd90;
         4'd2: r = 7'd80;
         4'd3: r = 7'd70;
         4'd4: r = 7'd60;
         4'd5: r = 7'd50;
         4'd6: r = 7'd40;
         4'd7: r = 7'd30;
         4'd8: r = 7'd20;
         4'd9: r = 7'd10;
         default: r = 7'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/bgme_ram.sv
module bgme_ram #(
   parameter int WIDTH = 12,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data <= mem_ff[rd_addr];
   end
endmodule

### rtl/bgme_queue.sv
module bgme_queue (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   input  bgme_pkg::gauge_job_type push_job,
   input  logic                    pop,
   output bgme_pkg::gauge_job_type head_job,
   output logic                    empty,
   output logic                    full
);
   import bgme_pkg::*;

   gauge_job_type entry_ff [2];
   logic wr_ptr_ff, wr_ptr_in;
   logic rd_ptr_ff, rd_ptr_in;
   logic [1:0] cnt_ff, cnt_in;

   assign empty = (cnt_ff == 2'd0);
   assign full = (cnt_ff == 2'd2);
   assign head_job = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      cnt_in = cnt_ff + 2'(push) - 2'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end
endmodule

### rtl/bgme_front.sv
module bgme_front #(
   parameter int WINDOW_MAX = bgme_pkg::WINDOW_MAX_DEF,
   parameter int ADC_BITS = bgme_pkg::ADC_BITS_DEF,
   localparam int CNT_W = $clog2(WINDOW_MAX + 1),
   localparam int IDX_W = $clog2(WINDOW_MAX)
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_stall,
   input  logic [ADC_BITS-1:0]         req_adc_sample,
   input  logic                        req_charge_pin_low,
   input  logic [CNT_W-1:0]            win_len,
   input  logic                        charge_enable,
   input  bgme_pkg::gauge_release_type release_bank,
   input  logic                        queue_full,
   output logic                        push,
   output bgme_pkg::gauge_job_type     push_job,
   output logic                        ram_wr_en,
   output logic [IDX_W:0]              ram_wr_addr,
   output logic [ADC_BITS-1:0]         ram_wr_data
);
   import bgme_pkg::*;

   logic [CNT_W-1:0] count_ff, count_in;
   logic wb_ff, wb_in;
   logic [1:0] busy_ff, busy_in;
   logic accept;
   logic [CNT_W-1:0] count_next;
   logic close;

   assign req_stall = busy_ff[wb_ff] || queue_full;
   assign accept = req_valid && !req_stall;
   assign count_next = count_ff + CNT_W'(1);
   assign close = (count_next >= win_len);

   assign ram_wr_en = accept;
   assign ram_wr_addr = {wb_ff, count_ff[IDX_W-1:0]};
   assign ram_wr_data = req_adc_sample;

   assign push = accept && close;
   assign push_job = '{bank: wb_ff, len: LEN_W'(win_len),
                       charging: req_charge_pin_low & charge_enable};

   always_comb begin
      count_in = count_ff;
      wb_in = wb_ff;
      busy_in = busy_ff;
      if (release_bank.valid) begin
         busy_in[release_bank.bank] = 1'b0;
      end
      if (accept) begin
         if (close) begin
            // hand the full bank to the back end, fill the other one
            count_in = '0;
            busy_in[wb_ff] = 1'b1;
            wb_in = ~wb_ff;
         end else begin
            count_in = count_next;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         wb_ff <= 1'b0;
         busy_ff <= 2'b00;
      end else begin
         count_ff <= count_in;
         wb_ff <= wb_in;
         busy_ff <= busy_in;
      end
   end
endmodule

### rtl/bgme_back.sv
module bgme_back #(
   parameter int WINDOW_MAX = bgme_pkg::WINDOW_MAX_DEF,
   parameter int ADC_BITS = bgme_pkg::ADC_BITS_DEF,
   localparam int CNT_W = $clog2(WINDOW_MAX + 1),
   localparam int IDX_W = $clog2(WINDOW_MAX)
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 queue_empty,
   input  bgme_pkg::gauge_job_type              head_job,
   output logic                                 pop,
   output bgme_pkg::gauge_release_type          release_bank,
   output logic [IDX_W:0]                       ram_rd_addr,
   input  logic [ADC_BITS-1:0]                  ram_rd_data,
   input  logic [bgme_pkg::ALPHA_W-1:0]         alpha,
   input  logic [bgme_pkg::SCALE_W-1:0]         scale,
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [bgme_pkg::MV_W-1:0]            rsp_voltage_mv,
   output logic [bgme_pkg::MV_W-1:0]            rsp_ema_mv,
   output logic [bgme_pkg::PCT_W-1:0]           rsp_percent,
   output logic                                 rsp_charging
);
   import bgme_pkg::*;

   localparam int SUM_W = ADC_BITS + 2;
   localparam int PP_W = SUM_W + 12;
   localparam int FULL_W = SUM_W + SCALE_W + 1;
   localparam int Q_W = FULL_W - 16;

   localparam logic [3:0] ST_IDLE = 4'd0;
   localparam logic [3:0] ST_READ = 4'd1;
   localparam logic [3:0] ST_WAIT = 4'd2;
   localparam logic [3:0] ST_SHIFT = 4'd3;
   localparam logic [3:0] ST_SUM = 4'd4;
   localparam logic [3:0] ST_MUL_LO = 4'd5;
   localparam logic [3:0] ST_MUL_HI = 4'd6;
   localparam logic [3:0] ST_SCALE = 4'd7;
   localparam logic [3:0] ST_DIV3 = 4'd8;
   localparam logic [3:0] ST_VOLT = 4'd9;
   localparam logic [3:0] ST_EMA_A = 4'd10;
   localparam logic [3:0] ST_EMA_B = 4'd11;
   localparam logic [3:0] ST_EMA_C = 4'd12;
   localparam logic [3:0] ST_EMA_D = 4'd13;
   localparam logic [3:0] ST_OUT = 4'd14;

   logic [3:0] state_ff, state_in;
   gauge_job_type job_ff;
   logic [CNT_W-1:0] len;
   logic [CNT_W-1:0] rd_idx_ff, rd_idx_in;
   logic [CNT_W-1:0] fill_ff, fill_in;
   logic [CNT_W-1:0] shift_cnt_ff, shift_cnt_in;
   logic pend_ff, pend_in;
   logic first_ff, first_in;
   logic rsp_valid_ff, rsp_valid_in;

   logic [ADC_BITS-1:0] sorted_ff [WINDOW_MAX];
   logic [ADC_BITS-1:0] ins [WINDOW_MAX];
   logic gt [WINDOW_MAX];

   logic [SUM_W-1:0] sum_ff;
   logic [PP_W-1:0] plo_ff, phi_ff;
   logic [FULL_W-1:0] full;
   logic [Q_W-1:0] q_ff;
   logic [32:0] p3_ff;
   logic sat_ff;
   logic [MV_W-1:0] v_ff;

   logic [3:0] seg, seg_ff;
   logic hi_ff, lo_ff;
   logic [MV_W-1:0] d, span;
   logic [18:0] d20;
   logic [3:0] k;
   logic [PCT_W-1:0] pct_ff;

   logic [ALPHA_W-1:0] a_eff, b_eff;
   logic [30:0] pa_ff, pb_ff;
   logic [32:0] pc_ff;
   logic [31:0] ema_mix;
   logic [EMA_W-1:0] ema_ff, ema_new;
   logic [30:0] ema_round;

   logic [MV_W-1:0] rsp_voltage_ff, rsp_ema_ff;
   logic [PCT_W-1:0] rsp_percent_ff;
   logic rsp_charging_ff;

   assign len = CNT_W'(job_ff.len);
   assign pop = (state_ff == ST_IDLE) && !queue_empty;
   assign ram_rd_addr = {job_ff.bank, rd_idx_ff[IDX_W-1:0]};
   assign release_bank = '{valid: (state_ff == ST_WAIT), bank: job_ff.bank};

   assign rsp_valid = rsp_valid_ff;
   assign rsp_voltage_mv = rsp_voltage_ff;
   assign rsp_ema_mv = rsp_ema_ff;
   assign rsp_percent = rsp_percent_ff;
   assign rsp_charging = rsp_charging_ff;

   // insertion into the sorted chain; unfilled slots count as larger than any sample
   always_comb begin
      for (int j = 0; j < WINDOW_MAX; j++) begin
         gt[j] = (CNT_W'(j) >= fill_ff) || (sorted_ff[j] > ram_rd_data);
      end
      ins[0] = gt[0] ? ram_rd_data : sorted_ff[0];
      for (int j = 1; j < WINDOW_MAX; j++) begin
         if (gt[j]) begin
            ins[j] = gt[j-1] ? sorted_ff[j-1] : ram_rd_data;
         end else begin
            ins[j] = sorted_ff[j];
         end
      end
   end

   assign full = (FULL_W'(phi_ff) << 12) + FULL_W'(plo_ff) + FULL_W'(98304);

   // first segment whose lower end the voltage reaches
   always_comb begin
      seg = 4'd9;
      for (int i = 9; i >= 0; i--) begin
         if (v_ff >= tbl_mv(4'(i + 1))) begin
            seg = 4'(i);
         end
      end
   end

   always_comb begin
      d = v_ff - tbl_mv(seg_ff + 4'd1);
      span = tbl_mv(seg_ff) - tbl_mv(seg_ff + 4'd1);
      d20 = (19'(d) << 4) + (19'(d) << 2);
      k = 4'd0;
      for (int i = 1; i <= 10; i++) begin
         if (d20 >= 19'(span) * 19'(2 * i - 1)) begin
            k = k + 4'd1;
         end
      end
   end

   always_comb begin
      if (alpha < ALPHA_MIN) begin
         a_eff = ALPHA_MIN;
      end else if (alpha > ALPHA_ONE) begin
         a_eff = ALPHA_ONE;
      end else begin
         a_eff = alpha;
      end
      b_eff = ALPHA_ONE - a_eff;
   end

   always_comb begin
      ema_mix = 32'(pa_ff) + 32'(pb_ff) + 32'((34'(pc_ff) + 34'd32768) >> 16);
      ema_new = first_ff ? {v_ff, 16'd0} : ema_mix[EMA_W-1:0];
      ema_round = 31'(ema_new) + 31'd32768;
   end

   always_comb begin
      state_in = state_ff;
      rd_idx_in = rd_idx_ff;
      fill_in = fill_ff;
      shift_cnt_in = shift_cnt_ff;
      pend_in = (state_ff == ST_READ);
      first_in = first_ff;
      rsp_valid_in = rsp_valid_ff;
      if (pend_ff) begin
         fill_in = fill_ff + CNT_W'(1);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               rd_idx_in = '0;
               fill_in = '0;
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            rd_idx_in = rd_idx_ff + CNT_W'(1);
            if (rd_idx_ff == len - CNT_W'(1)) begin
               state_in = ST_WAIT;
            end
         end
         ST_WAIT: begin
            shift_cnt_in = (len >> 1) - CNT_W'(1);
            state_in = ST_SHIFT;
         end
         ST_SHIFT: begin
            if (shift_cnt_ff == '0) begin
               state_in = ST_SUM;
            end else begin
               shift_cnt_in = shift_cnt_ff - CNT_W'(1);
            end
         end
         ST_SUM: state_in = ST_MUL_LO;
         ST_MUL_LO: state_in = ST_MUL_HI;
         ST_MUL_HI: state_in = ST_SCALE;
         ST_SCALE: state_in = ST_DIV3;
         ST_DIV3: state_in = ST_VOLT;
         ST_VOLT: state_in = ST_EMA_A;
         ST_EMA_A: state_in = ST_EMA_B;
         ST_EMA_B: state_in = ST_EMA_C;
         ST_EMA_C: state_in = ST_EMA_D;
         ST_EMA_D: begin
            first_in = 1'b0;
            rsp_valid_in = 1'b1;
            state_in = ST_OUT;
         end
         ST_OUT: begin
            if (!rsp_stall) begin
               rsp_valid_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rd_idx_ff <= '0;
         fill_ff <= '0;
         shift_cnt_ff <= '0;
         pend_ff <= 1'b0;
         first_ff <= 1'b1;
         rsp_valid_ff <= 1'b0;
         ema_ff <= '0;
      end else begin
         state_ff <= state_in;
         rd_idx_ff <= rd_idx_in;
         fill_ff <= fill_in;
         shift_cnt_ff <= shift_cnt_in;
         pend_ff <= pend_in;
         first_ff <= first_in;
         rsp_valid_ff <= rsp_valid_in;
         if (state_ff == ST_EMA_D) begin
            ema_ff <= ema_new;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         job_ff <= head_job;
      end
      if (pend_ff) begin
         sorted_ff <= ins;
      end else if (state_ff == ST_SHIFT && shift_cnt_ff != '0) begin
         // advance toward the median: drop the smallest
         for (int j = 0; j < WINDOW_MAX - 1; j++) begin
            sorted_ff[j] <= sorted_ff[j+1];
         end
      end
      unique case (state_ff)
         ST_SUM: sum_ff <= SUM_W'(sorted_ff[0]) + SUM_W'(sorted_ff[1]) + SUM_W'(sorted_ff[2]);
         ST_MUL_LO: plo_ff <= PP_W'(sum_ff) * PP_W'(scale[11:0]);
         ST_MUL_HI: phi_ff <= PP_W'(sum_ff) * PP_W'(scale[23:12]);
         ST_SCALE: q_ff <= full[FULL_W-1:16];
         ST_DIV3: begin
            // divide by three through the reciprocal, saturate first
            sat_ff <= (q_ff >= Q_W'(49152));
            p3_ff <= 33'(q_ff[15:0]) * 33'd43691;
         end
         ST_VOLT: v_ff <= sat_ff ? V_SAT : p3_ff[30:17];
         ST_EMA_A: begin
            pa_ff <= 31'(a_eff) * 31'(v_ff);
            seg_ff <= seg;
            hi_ff <= (v_ff >= tbl_mv(4'd0));
            lo_ff <= (v_ff <= tbl_mv(4'd10));
         end
         ST_EMA_B: begin
            pb_ff <= 31'(b_eff) * 31'(ema_ff[29:16]);
            if (hi_ff) begin
               pct_ff <= tbl_pct(4'd0);
            end else if (lo_ff) begin
               pct_ff <= tbl_pct(4'd10);
            end else begin
               pct_ff <= tbl_pct(seg_ff + 4'd1) + PCT_W'(k);
            end
         end
         ST_EMA_C: pc_ff <= 33'(b_eff) * 33'(ema_ff[15:0]);
         ST_EMA_D: begin
            rsp_voltage_ff <= v_ff;
            rsp_ema_ff <= ema_round[29:16];
            rsp_percent_ff <= pct_ff;
            rsp_charging_ff <= job_ff.charging;
         end
         default: ;
      endcase
   end
endmodule

### rtl/battery_gauge_median_ema.sv
// channel | handshake            | payload
// req     | req_valid/req_stall  | req_adc_sample, req_charge_pin_low
// rsp     | rsp_valid/rsp_stall  | rsp_voltage_mv, rsp_ema_mv, rsp_percent, rsp_charging
// csr     | csr_write_enable     | csr_index, csr_write_data
//
// A sample is taken every cycle while req is not stalled, into one of two window banks; one beat per window leaves rsp.
// Window close: the back end picks up the job, reads and insertion-sorts the bank, shifts down
// to the middle, runs the arithmetic, then the result waits in the rsp register until taken.
// req stalls only while both banks await the back end or the job queue is full.
// Synchronous reset clears counters, EMA state and handshakes; the window RAM is not cleared.
module battery_gauge_median_ema #(
   parameter int WINDOW_MAX = bgme_pkg::WINDOW_MAX_DEF,
   parameter int ADC_BITS = bgme_pkg::ADC_BITS_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [ADC_BITS-1:0]             req_adc_sample,
   input  logic                            req_charge_pin_low,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic [bgme_pkg::MV_W-1:0]       rsp_voltage_mv,
   output logic [bgme_pkg::MV_W-1:0]       rsp_ema_mv,
   output logic [bgme_pkg::PCT_W-1:0]      rsp_percent,
   output logic                            rsp_charging,
   input  logic                            csr_write_enable,
   input  logic [bgme_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [bgme_pkg::CSR_DATA_W-1:0] csr_write_data
);
   import bgme_pkg::*;

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W = $clog2(WINDOW_MAX);

   logic [5:0] spw_ff;
   logic [ALPHA_W-1:0] alpha_ff;
   logic [SCALE_W-1:0] scale_ff;
   logic charge_en_ff;
   logic [CNT_W-1:0] win_len;

   gauge_release_type release_bank;
   gauge_job_type push_job, head_job;
   logic push, pop, q_empty, q_full;
   logic ram_wr_en;
   logic [IDX_W:0] ram_wr_addr, ram_rd_addr;
   logic [ADC_BITS-1:0] ram_wr_data, ram_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         spw_ff <= 6'd20;
         alpha_ff <= 17'd13107;
         scale_ff <= 24'd105627;
         charge_en_ff <= 1'b1;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            REG_SAMPLES: spw_ff <= csr_write_data[5:0];
            REG_ALPHA: alpha_ff <= csr_write_data[ALPHA_W-1:0];
            REG_SCALE: scale_ff <= csr_write_data[SCALE_W-1:0];
            REG_CHARGE: charge_en_ff <= csr_write_data[0];
            default: ;
         endcase
      end
   end

   always_comb begin
      if (spw_ff < 6'd3) begin
         win_len = CNT_W'(3);
      end else if (8'(spw_ff) > 8'(WINDOW_MAX)) begin
         win_len = CNT_W'(WINDOW_MAX);
      end else begin
         win_len = CNT_W'(spw_ff);
      end
   end

   bgme_front #(.WINDOW_MAX(WINDOW_MAX), .ADC_BITS(ADC_BITS)) u_front (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_adc_sample(req_adc_sample),
      .req_charge_pin_low(req_charge_pin_low),
      .win_len(win_len),
      .charge_enable(charge_en_ff),
      .release_bank(release_bank),
      .queue_full(q_full),
      .push(push),
      .push_job(push_job),
      .ram_wr_en(ram_wr_en),
      .ram_wr_addr(ram_wr_addr),
      .ram_wr_data(ram_wr_data)
   );

   bgme_ram #(.WIDTH(ADC_BITS), .DEPTH(2 * (1 << IDX_W))) u_ram (
      .clock(clock),
      .wr_en(ram_wr_en),
      .wr_addr(ram_wr_addr),
      .wr_data(ram_wr_data),
      .rd_addr(ram_rd_addr),
      .rd_data(ram_rd_data)
   );

   bgme_queue u_queue (
      .clock(clock),
      .reset(reset),
      .push(push),
      .push_job(push_job),
      .pop(pop),
      .head_job(head_job),
      .empty(q_empty),
      .full(q_full)
   );

   bgme_back #(.WINDOW_MAX(WINDOW_MAX), .ADC_BITS(ADC_BITS)) u_back (
      .clock(clock),
      .reset(reset),
      .queue_empty(q_empty),
      .head_job(head_job),
      .pop(pop),
      .release_bank(release_bank),
      .ram_rd_addr(ram_rd_addr),
      .ram_rd_data(ram_rd_data),
      .alpha(alpha_ff),
      .scale(scale_ff),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_voltage_mv(rsp_voltage_mv),
      .rsp_ema_mv(rsp_ema_mv),
      .rsp_percent(rsp_percent),
      .rsp_charging(rsp_charging)
   );
endmodule
